// ===== hw/rtl/cti_pkg.sv =====
// Shared types, constants and helper functions for the canonical ternary index block.
package cti_pkg;

  localparam int VAL_W          = 32;
  localparam int LEN_W          = 5;
  localparam int MODE_W         = 2;
  localparam int MAX_DIGITS_DEF = 20;
  localparam int SQUARE_CELLS   = 9;
  localparam int D4_COUNT       = 8;
  localparam int SQ_W           = 15;
  localparam int POW_W          = 34;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE    = 2'd0,
    MODE_REVERSE = 2'd1,
    MODE_SQUARE  = 2'd2,
    MODE_UNSUP   = 2'd3
  } mode_t;

  // Source cell for each output digit; row 0 is the identity.
  localparam logic [3:0] D4_PERM [D4_COUNT][SQUARE_CELLS] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd6, 4'd3, 4'd0, 4'd7, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2},
    '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
    '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6},
    '{4'd2, 4'd1, 4'd0, 4'd5, 4'd4, 4'd3, 4'd8, 4'd7, 4'd6},
    '{4'd6, 4'd7, 4'd8, 4'd3, 4'd4, 4'd5, 4'd0, 4'd1, 4'd2},
    '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8},
    '{4'd8, 4'd5, 4'd2, 4'd7, 4'd4, 4'd1, 4'd6, 4'd3, 4'd0}
  };

  typedef struct packed {
    logic [VAL_W-1:0]                 idx;
    logic [VAL_W-1:0]                 rem;
    logic [VAL_W-1:0]                 rev;
    logic [VAL_W-1:0]                 place;
    logic [LEN_W-1:0]                 len;
    mode_t                            mode;
    logic                             ok;
    logic [D4_COUNT-1:1][SQ_W-1:0]    acc;
  } lane_t;

  function automatic logic [POW_W-1:0] pow3(input int n);
    logic [POW_W-1:0] p;
    p = POW_W'(1);
    for (int i = 0; i < n; i++) begin
      p = p * POW_W'(3);
    end
    return p;
  endfunction

  // Weight that source cell s carries in the re-encoding under transform t.
  function automatic logic [SQ_W-1:0] d4_weight(input int t, input int s);
    logic [POW_W-1:0] p;
    logic [SQ_W-1:0]  w;
    w = '0;
    p = POW_W'(1);
    for (int k = 0; k < SQUARE_CELLS; k++) begin
      if (int'(D4_PERM[t][k]) == s) begin
        w = p[SQ_W-1:0];
      end
      p = p * POW_W'(3);
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/cti_query_if.sv =====
// Input channel carrying one pattern word with its length and symmetry mode.
interface cti_query_if;
  import cti_pkg::*;

  logic                valid;
  logic                ready;
  logic [VAL_W-1:0]    pattern_index;
  logic [LEN_W-1:0]    pattern_len;
  logic [MODE_W-1:0]   symmetry_mode;

  modport source (output valid, pattern_index, pattern_len, symmetry_mode, input ready);
  modport sink   (input valid, pattern_index, pattern_len, symmetry_mode, output ready);
endinterface

// ===== hw/rtl/cti_answer_if.sv =====
// Output channel carrying one canonical index word and its validity flag.
interface cti_answer_if;
  import cti_pkg::*;

  logic                valid;
  logic                ready;
  logic [VAL_W-1:0]    canonical_index;
  logic                valid_res;

  modport source (output valid, canonical_index, valid_res, input ready);
  modport sink   (input valid, canonical_index, valid_res, output ready);
endinterface

// ===== hw/rtl/cti_cell.sv =====
// One digit cell: extracts a ternary digit and folds it into the reversed and square sums.
module cti_cell #(
  parameter int DIGIT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  cti_pkg::lane_t  up_lane,
  output logic            valid,
  input  logic            down_ready,
  output cti_pkg::lane_t  lane
);
  import cti_pkg::*;

  localparam logic [POW_W-1:0] W_FULL  = pow3(DIGIT);
  localparam logic [POW_W-1:0] W2_FULL = W_FULL + W_FULL;
  localparam logic [VAL_W:0]   WEIGHT  = W_FULL[VAL_W:0];
  localparam logic [VAL_W:0]   WEIGHT2 = W2_FULL[VAL_W:0];

  logic [VAL_W:0]                  rem_ext;
  logic [VAL_W:0]                  sub;
  logic [1:0]                      digit;
  logic                            active;
  logic [VAL_W-1:0]                addend;
  logic [D4_COUNT-1:1][SQ_W-1:0]   acc_add;
  lane_t                           lane_next;

  assign up_ready = !valid || down_ready;

  always_comb begin
    rem_ext = {1'b0, up_lane.rem};
    if (rem_ext >= WEIGHT2) begin
      digit = 2'd2;
      sub   = WEIGHT2;
    end else if (rem_ext >= WEIGHT) begin
      digit = 2'd1;
      sub   = WEIGHT;
    end else begin
      digit = 2'd0;
      sub   = '0;
    end
  end

  for (genvar t = 1; t < D4_COUNT; t++) begin : g_sq
    if (DIGIT < SQUARE_CELLS) begin : g_on
      localparam logic [SQ_W-1:0] WT = d4_weight(t, DIGIT);
      always_comb begin
        case (digit)
          2'd1:    acc_add[t] = WT;
          2'd2:    acc_add[t] = {WT[SQ_W-2:0], 1'b0};
          default: acc_add[t] = '0;
        endcase
      end
    end else begin : g_off
      assign acc_add[t] = '0;
    end
  end

  always_comb begin
    active = up_lane.len > LEN_W'(DIGIT);
    case (digit)
      2'd1:    addend = up_lane.place;
      2'd2:    addend = {up_lane.place[VAL_W-2:0], 1'b0};
      default: addend = '0;
    endcase
    lane_next     = up_lane;
    lane_next.rem = VAL_W'(rem_ext - sub);
    if (active) begin
      lane_next.rev   = up_lane.rev + addend;
      lane_next.place = up_lane.place + {up_lane.place[VAL_W-2:0], 1'b0};
    end
    for (int t = 1; t < D4_COUNT; t++) begin
      lane_next.acc[t] = up_lane.acc[t] + acc_add[t];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      lane <= lane_next;
    end
  end

endmodule

// ===== hw/rtl/cti_reduce.sv =====
// Final stage: picks the smallest index over the allowed transforms into the output register.
module cti_reduce (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  cti_pkg::lane_t  up_lane,
  cti_answer_if.source    answer
);
  import cti_pkg::*;

  logic [SQ_W-1:0]   lvl1 [4];
  logic [SQ_W-1:0]   lvl2 [2];
  logic [SQ_W-1:0]   sq_best;
  logic [VAL_W-1:0]  cand;
  logic [VAL_W-1:0]  index_next;
  logic              out_valid;

  assign up_ready     = !out_valid || answer.ready;
  assign answer.valid = out_valid;

  always_comb begin
    lvl1[0] = (up_lane.acc[1] < up_lane.idx[SQ_W-1:0]) ? up_lane.acc[1] : up_lane.idx[SQ_W-1:0];
    lvl1[1] = (up_lane.acc[3] < up_lane.acc[2]) ? up_lane.acc[3] : up_lane.acc[2];
    lvl1[2] = (up_lane.acc[5] < up_lane.acc[4]) ? up_lane.acc[5] : up_lane.acc[4];
    lvl1[3] = (up_lane.acc[7] < up_lane.acc[6]) ? up_lane.acc[7] : up_lane.acc[6];
    lvl2[0] = (lvl1[1] < lvl1[0]) ? lvl1[1] : lvl1[0];
    lvl2[1] = (lvl1[3] < lvl1[2]) ? lvl1[3] : lvl1[2];
    sq_best = (lvl2[1] < lvl2[0]) ? lvl2[1] : lvl2[0];
    cand = up_lane.idx;
    case (up_lane.mode)
      MODE_REVERSE: begin
        if (up_lane.rev < up_lane.idx) begin
          cand = up_lane.rev;
        end
      end
      MODE_SQUARE: cand = VAL_W'(sq_best);
      default:     cand = up_lane.idx;
    endcase
    index_next = up_lane.ok ? cand : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      answer.canonical_index <= index_next;
      answer.valid_res       <= up_lane.ok;
    end
  end

endmodule

// ===== hw/rtl/canonical_ternary_index.sv =====
// Top level of the canonical ternary index block: entry stage, digit cell chain, output stage.
// A pattern word enters on the query channel with valid and ready; a word is taken at a
// rising edge where both are high. Each query gives exactly one answer word on the answer
// channel: canonical_index, the smallest base-3 index over the transforms that the
// symmetry mode allows, and valid_res, which is low (with index 0) for a bad length,
// an out-of-range index, an unsupported mode, or square mode with a length other than 9.
// The word passes an entry register, a chain of MAX_DIGITS digit cells, one per ternary
// digit from the most significant down, and the output register. The chain accepts a new
// query every cycle unless a stall from answer.ready holds it.
// When the receiver holds answer.ready low, the answer stays in the output register and
// the stages behind it keep filling until the chain is full; only then does query.ready
// fall. Empty stages are squeezed out, so no bubble is kept while stalled.
// Synchronous reset empties every stage; no answer is pending after reset.
module canonical_ternary_index #(
  parameter int MAX_DIGITS = cti_pkg::MAX_DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cti_query_if.sink    query,
  cti_answer_if.source answer
);
  import cti_pkg::*;

  logic              stg_valid [MAX_DIGITS+1];
  logic              stg_ready [MAX_DIGITS+2];
  lane_t             stg_lane  [MAX_DIGITS+1];
  lane_t             entry_next;
  logic [POW_W-1:0]  limit;
  logic              len_ok;
  logic              mode_ok;

  assign stg_ready[0] = !stg_valid[0] || stg_ready[1];
  assign query.ready  = stg_ready[0];

  always_comb begin
    limit = '0;
    for (int i = 1; i <= MAX_DIGITS; i++) begin
      if (query.pattern_len == LEN_W'(i)) begin
        limit = pow3(i);
      end
    end
    len_ok  = (query.pattern_len != '0) && (query.pattern_len <= LEN_W'(MAX_DIGITS));
    mode_ok = (mode_t'(query.symmetry_mode) != MODE_UNSUP)
           && !((mode_t'(query.symmetry_mode) == MODE_SQUARE)
                && (query.pattern_len != LEN_W'(SQUARE_CELLS)));
    entry_next       = '0;
    entry_next.idx   = query.pattern_index;
    entry_next.rem   = query.pattern_index;
    entry_next.place = VAL_W'(1);
    entry_next.len   = query.pattern_len;
    entry_next.mode  = mode_t'(query.symmetry_mode);
    entry_next.ok    = len_ok && mode_ok && ({2'b00, query.pattern_index} < limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid[0] <= 1'b0;
    end else if (stg_ready[0]) begin
      stg_valid[0] <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[0]) begin
      stg_lane[0] <= entry_next;
    end
  end

  for (genvar i = 1; i <= MAX_DIGITS; i++) begin : g_cell
    cti_cell #(
      .DIGIT (MAX_DIGITS - i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (stg_valid[i-1]),
      .up_ready   (stg_ready[i]),
      .up_lane    (stg_lane[i-1]),
      .valid      (stg_valid[i]),
      .down_ready (stg_ready[i+1]),
      .lane       (stg_lane[i])
    );
  end

  cti_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[MAX_DIGITS]),
    .up_ready (stg_ready[MAX_DIGITS+1]),
    .up_lane  (stg_lane[MAX_DIGITS]),
    .answer   (answer)
  );

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    answer.valid && !answer.valid_res |-> answer.canonical_index == '0)
    else $error("invalid answer word carries a nonzero index");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !query.ready |-> answer.valid && !answer.ready)
    else $error("query stalled while the output side is free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !answer.valid)
    else $error("answer word pending right after reset");
`endif

endmodule
